// ===== rtl/hsy_pkg.sv =====
// Package for the Hermite segment y-at-x block.
// Holds the segment struct, format constants and the saturation helper; no dependencies.
`default_nettype none
package hsy_pkg;

  localparam int unsigned COORD_W      = 32;
  localparam int unsigned HALVINGS_DEF = 20;
  localparam int unsigned FRAC_DEF     = 20;
  localparam int unsigned SUM_W        = 37;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0x;
    logic signed [COORD_W-1:0] p0y;
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [COORD_W-1:0] m0x;
    logic signed [COORD_W-1:0] m0y;
    logic signed [COORD_W-1:0] m1x;
    logic signed [COORD_W-1:0] m1y;
    logic signed [COORD_W-1:0] tx;
  } seg_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = SUM_W'(32'sh7fffffff);
    lo_lim = -hi_lim - SUM_W'(1);
    if (v > hi_lim) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo_lim) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hsy_iter.sv =====
// One bisection step of the Hermite segment search, cut into four register stages.
// Depends on hsy_pkg for the segment struct and saturation.
`default_nettype none
module hsy_iter
  import hsy_pkg::*;
#(
  parameter int unsigned FRAC = FRAC_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire seg_t           seg_i,
  input  wire logic [FRAC:0]  lo_i,
  input  wire logic [FRAC:0]  hi_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output seg_t                seg_o,
  output logic [FRAC:0]       lo_o,
  output logic [FRAC:0]       hi_o,
  output logic signed [COORD_W-1:0] y_o
);

  localparam int unsigned TW = FRAC + 1;
  localparam int unsigned HW = FRAC + 3;
  localparam int unsigned PW = COORD_W + HW;
  localparam int unsigned QW = SUM_W - 2;

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic va_q, vb_q, vc_q, vd_q;

  assign rdy_d = !vd_q || out_ready_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // Stage A: midpoint and its square.
  seg_t seg_a_q;
  logic [TW-1:0] lo_a_q, hi_a_q, t_a_q, t2_a_q;
  logic [TW-1:0] t_a_d, t2_a_d;
  logic [TW:0] mid_sum;
  logic [2*TW-1:0] sq;

  always_comb begin
    mid_sum = {1'b0, lo_i} + {1'b0, hi_i};
    t_a_d   = mid_sum[TW:1];
    sq      = (2*TW)'(t_a_d) * (2*TW)'(t_a_d);
    t2_a_d  = TW'(sq >> FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      seg_a_q <= seg_i;
      lo_a_q  <= lo_i;
      hi_a_q  <= hi_i;
      t_a_q   <= t_a_d;
      t2_a_q  <= t2_a_d;
    end
  end

  // Stage B: cube and the four basis weights.
  seg_t seg_b_q;
  logic [TW-1:0] lo_b_q, hi_b_q, t_b_q;
  logic signed [HW-1:0] h00_b_q, h10_b_q, h01_b_q, h11_b_q;
  logic [2*TW-1:0] cu;
  logic signed [HW-1:0] st, s2, s3, one_h;
  logic signed [HW-1:0] h00_d, h10_d, h01_d, h11_d;

  always_comb begin
    cu    = (2*TW)'(t2_a_q) * (2*TW)'(t_a_q);
    st    = $signed({2'b00, t_a_q});
    s2    = $signed({2'b00, t2_a_q});
    s3    = $signed({2'b00, TW'(cu >> FRAC)});
    one_h = $signed(HW'(1) << FRAC);
    h00_d = (s3 <<< 1) - (s2 + (s2 <<< 1)) + one_h;
    h10_d = s3 - (s2 <<< 1) + st;
    h01_d = (s2 + (s2 <<< 1)) - (s3 <<< 1);
    h11_d = s3 - s2;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      seg_b_q <= seg_a_q;
      lo_b_q  <= lo_a_q;
      hi_b_q  <= hi_a_q;
      t_b_q   <= t_a_q;
      h00_b_q <= h00_d;
      h10_b_q <= h10_d;
      h01_b_q <= h01_d;
      h11_b_q <= h11_d;
    end
  end

  // Stage C: eight weighted terms, each floored back to Q16.16.
  seg_t seg_c_q;
  logic [TW-1:0] lo_c_q, hi_c_q, t_c_q;
  logic signed [QW-1:0] qx_c_q [4];
  logic signed [QW-1:0] qy_c_q [4];
  logic signed [PW-1:0] px [4];
  logic signed [PW-1:0] py [4];

  always_comb begin
    px[0] = PW'(seg_b_q.p0x) * PW'(h00_b_q);
    px[1] = PW'(seg_b_q.m0x) * PW'(h10_b_q);
    px[2] = PW'(seg_b_q.p1x) * PW'(h01_b_q);
    px[3] = PW'(seg_b_q.m1x) * PW'(h11_b_q);
    py[0] = PW'(seg_b_q.p0y) * PW'(h00_b_q);
    py[1] = PW'(seg_b_q.m0y) * PW'(h10_b_q);
    py[2] = PW'(seg_b_q.p1y) * PW'(h01_b_q);
    py[3] = PW'(seg_b_q.m1y) * PW'(h11_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      seg_c_q <= seg_b_q;
      lo_c_q  <= lo_b_q;
      hi_c_q  <= hi_b_q;
      t_c_q   <= t_b_q;
      for (int i = 0; i < 4; i++) begin
        qx_c_q[i] <= QW'(px[i] >>> FRAC);
        qy_c_q[i] <= QW'(py[i] >>> FRAC);
      end
    end
  end

  // Stage D: sums, saturation and the bound update.
  seg_t seg_d_q;
  logic [TW-1:0] lo_d_q, hi_d_q;
  logic signed [COORD_W-1:0] y_d_q;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [COORD_W-1:0] xs;

  always_comb begin
    sx = SUM_W'(qx_c_q[0]) + SUM_W'(qx_c_q[1]) + SUM_W'(qx_c_q[2]) + SUM_W'(qx_c_q[3]);
    sy = SUM_W'(qy_c_q[0]) + SUM_W'(qy_c_q[1]) + SUM_W'(qy_c_q[2]) + SUM_W'(qy_c_q[3]);
    xs = sat32(sx);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      seg_d_q <= seg_c_q;
      y_d_q   <= sat32(sy);
      if (xs < seg_c_q.tx) begin
        lo_d_q <= t_c_q;
        hi_d_q <= hi_c_q;
      end else begin
        lo_d_q <= lo_c_q;
        hi_d_q <= t_c_q;
      end
    end
  end

  assign out_valid_o = vd_q;
  assign seg_o       = seg_d_q;
  assign lo_o        = lo_d_q;
  assign hi_o        = hi_d_q;
  assign y_o         = y_d_q;

  a_mid_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> (lo_a_q <= t_a_q) && (t_a_q <= hi_a_q))
    else $error("midpoint left its bounds");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |-> (lo_d_q <= hi_d_q))
    else $error("bounds crossed");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q && !out_ready_i) |=> (vd_q && $stable(y_d_q) && $stable(lo_d_q)))
    else $error("stalled step result changed");

endmodule
`default_nettype wire

// ===== rtl/hermite_segment_y_at_x.sv =====
// Top level of the Hermite segment y-at-x block.
// Chains HALVINGS instances of hsy_iter; depends on hsy_pkg.
`default_nettype none
// Usage:
// Each input transaction carries one cubic Hermite segment (start and end
// points, their tangents, all signed Q16.16) and a target x. The block
// bisects the curve parameter t on [0,1] and returns, in one output
// transaction, the saturated curve y at the last midpoint evaluated.
// Both channels use valid and ready; a transaction is taken when both are
// high at a rising clock edge.
// Every halving is a four-stage slice (midpoint and square, cube and basis
// weights, the eight products, sums and bound update). One transaction can
// enter every cycle and the throughput is one result per cycle, as long as
// the receiver does not stall the output.
// Reset clears only the valid bits of the stages; no state is kept between
// transactions. When the receiver stalls, the result is held in the final
// register and each stage still accepts data while it holds an empty slot,
// so bubbles are squeezed out and nothing is lost or repeated.
module hermite_segment_y_at_x
  import hsy_pkg::*;
#(
  parameter int unsigned HALVINGS        = HALVINGS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = FRAC_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [COORD_W-1:0]   start_x_i,
  input  wire logic signed [COORD_W-1:0]   start_y_i,
  input  wire logic signed [COORD_W-1:0]   end_x_i,
  input  wire logic signed [COORD_W-1:0]   end_y_i,
  input  wire logic signed [COORD_W-1:0]   start_slope_x_i,
  input  wire logic signed [COORD_W-1:0]   start_slope_y_i,
  input  wire logic signed [COORD_W-1:0]   end_slope_x_i,
  input  wire logic signed [COORD_W-1:0]   end_slope_y_i,
  input  wire logic signed [COORD_W-1:0]   target_x_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [COORD_W-1:0]        curve_y_o
);

  localparam int unsigned TW = PARAM_FRAC_BITS + 1;

  // Links between the slices; index 0 is the block input.
  logic              vld   [HALVINGS+1];
  logic              rdy   [HALVINGS+1];
  seg_t              seg   [HALVINGS+1];
  logic [TW-1:0]     lo    [HALVINGS+1];
  logic [TW-1:0]     hi    [HALVINGS+1];
  logic signed [COORD_W-1:0] y [HALVINGS];

  // The search starts over the whole interval, zero to one.
  assign vld[0] = in_valid_i;
  assign seg[0] = '{p0x: start_x_i, p0y: start_y_i, p1x: end_x_i, p1y: end_y_i,
                    m0x: start_slope_x_i, m0y: start_slope_y_i,
                    m1x: end_slope_x_i, m1y: end_slope_y_i, tx: target_x_i};
  assign lo[0]  = '0;
  assign hi[0]  = TW'(1) << PARAM_FRAC_BITS;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < HALVINGS; k++) begin : g_step
    hsy_iter #(
      .FRAC(PARAM_FRAC_BITS)
    ) u_iter (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (vld[k]),
      .in_ready_o (rdy[k]),
      .seg_i      (seg[k]),
      .lo_i       (lo[k]),
      .hi_i       (hi[k]),
      .out_valid_o(vld[k+1]),
      .out_ready_i(rdy[k+1]),
      .seg_o      (seg[k+1]),
      .lo_o       (lo[k+1]),
      .hi_o       (hi[k+1]),
      .y_o        (y[k])
    );
  end

  // The final slice's register is the output register.
  assign rdy[HALVINGS] = out_ready_i;
  assign out_valid_o   = vld[HALVINGS];
  assign curve_y_o     = y[HALVINGS-1];

endmodule
`default_nettype wire

// ===== tb/hsy_checker.sv =====
// Checker for the Hermite segment y-at-x block: watches both channels,
// predicts curve y per input transaction and compares in order. Depends on hsy_pkg.
`timescale 1ns / 1ps
module hsy_checker
  import hsy_pkg::*;
#(
  parameter int unsigned HALVINGS        = HALVINGS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = FRAC_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic signed [COORD_W-1:0] start_x_i,
  input  wire logic signed [COORD_W-1:0] start_y_i,
  input  wire logic signed [COORD_W-1:0] end_x_i,
  input  wire logic signed [COORD_W-1:0] end_y_i,
  input  wire logic signed [COORD_W-1:0] start_slope_x_i,
  input  wire logic signed [COORD_W-1:0] start_slope_y_i,
  input  wire logic signed [COORD_W-1:0] end_slope_x_i,
  input  wire logic signed [COORD_W-1:0] end_slope_y_i,
  input  wire logic signed [COORD_W-1:0] target_x_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic signed [COORD_W-1:0] curve_y_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o
);

  logic signed [COORD_W-1:0] expected_y_q[$];

  // Weighted sum of four Q16.16 terms, each floored by the fraction width, then clamped.
  function automatic longint hermite_blend(longint p0, longint m0, longint p1, longint m1,
                                           longint w00, longint w10, longint w01,
                                           longint w11);
    longint acc;
    acc = ((p0 * w00) >>> PARAM_FRAC_BITS) + ((m0 * w10) >>> PARAM_FRAC_BITS)
        + ((p1 * w01) >>> PARAM_FRAC_BITS) + ((m1 * w11) >>> PARAM_FRAC_BITS);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  function automatic logic signed [COORD_W-1:0] solve_curve_y(seg_t s);
    longint unsigned lo, hi, t, t2, t3, unity;
    longint w00, w10, w01, w11, cx, cy;
    unity = 64'd1 << PARAM_FRAC_BITS;
    lo = 0;
    hi = unity;
    cy = 0;
    for (int k = 0; k < HALVINGS; k++) begin
      t  = (lo + hi) >> 1;
      t2 = (t * t) >> PARAM_FRAC_BITS;
      t3 = (t2 * t) >> PARAM_FRAC_BITS;
      w00 = 2 * longint'(t3) - 3 * longint'(t2) + longint'(unity);
      w10 = longint'(t3) - 2 * longint'(t2) + longint'(t);
      w01 = 3 * longint'(t2) - 2 * longint'(t3);
      w11 = longint'(t3) - longint'(t2);
      cx = hermite_blend(s.p0x, s.m0x, s.p1x, s.m1x, w00, w10, w01, w11);
      cy = hermite_blend(s.p0y, s.m0y, s.p1y, s.m1y, w00, w10, w01, w11);
      if (cx < longint'(s.tx)) lo = t;
      else hi = t;
    end
    return cy[COORD_W-1:0];
  endfunction

  assign pending_o = expected_y_q.size();

  always @(posedge clk_i) begin
    seg_t s;
    logic signed [COORD_W-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        s = '{start_x_i, start_y_i, end_x_i, end_y_i, start_slope_x_i, start_slope_y_i,
              end_slope_x_i, end_slope_y_i, target_x_i};
        expected_y_q.push_back(solve_curve_y(s));
      end
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_y_q.size() == 0) begin
          errors_o <= errors_o + 1;
          $display("%0t: unexpected result, expected none, actual %0d", $time, curve_y_i);
        end else begin
          want = expected_y_q.pop_front();
          if (want !== curve_y_i) begin
            errors_o <= errors_o + 1;
            $display("%0t: curve_y mismatch, expected %0d, actual %0d", $time, want,
                     curve_y_i);
          end
        end
      end
    end
  end

  initial begin
    errors_o  = 0;
    results_o = 0;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for the Hermite segment y-at-x block.
// Drives segments with random gaps and stalls; depends on hsy_pkg and hsy_checker.
`timescale 1ns / 1ps
module tb_top;
  import hsy_pkg::*;

  localparam int LATENCY = 4 * HALVINGS_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] curve_y;
  seg_t seg = '0;
  int errors, pending, results;
  int src_idle_pct, dst_idle_pct;
  bit dst_hold = 1'b0;
  int sent = 0;

  initial forever #2 clk_i = ~clk_i;

  hermite_segment_y_at_x DUT (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .start_x_i(seg.p0x), .start_y_i(seg.p0y), .end_x_i(seg.p1x), .end_y_i(seg.p1y),
    .start_slope_x_i(seg.m0x), .start_slope_y_i(seg.m0y),
    .end_slope_x_i(seg.m1x), .end_slope_y_i(seg.m1y), .target_x_i(seg.tx),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .curve_y_o(curve_y)
  );

  hsy_checker CHK (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .start_x_i(seg.p0x), .start_y_i(seg.p0y), .end_x_i(seg.p1x), .end_y_i(seg.p1y),
    .start_slope_x_i(seg.m0x), .start_slope_y_i(seg.m0y),
    .end_slope_x_i(seg.m1x), .end_slope_y_i(seg.m1y), .target_x_i(seg.tx),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .curve_y_i(curve_y),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // The receiver decides readiness afresh every cycle, unless a long hold-off is running.
  always @(posedge clk_i) begin
    if (rst_ni) out_ready <= !dst_hold && ($urandom_range(99) >= dst_idle_pct);
  end

  // A random coordinate: full range, an extreme, a small value or a moderate one.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(131072))) - 32'sd65536;
      3, 4: return $signed(32'($urandom_range(2000000))) - 32'sd1000000;
      default: return $signed($urandom());
    endcase
  endfunction

  // Mostly ends spread on x, tangents of like scale, target near the span; else random.
  function automatic seg_t rand_segment();
    seg_t s;
    int span;
    if ($urandom_range(9) < 2) begin
      s = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      return s;
    end
    span  = $urandom_range(1 << 24) + 1;
    s.p0x = $signed(32'($urandom_range(1 << 26))) - 32'sd33554432;
    s.p1x = s.p0x + span;
    s.p0y = $signed($urandom()) >>> $urandom_range(8);
    s.p1y = $signed($urandom()) >>> $urandom_range(8);
    s.m0x = $signed(32'($urandom_range(2 * span))) - span / 4;
    s.m1x = $signed(32'($urandom_range(2 * span))) - span / 4;
    s.m0y = $signed($urandom()) >>> $urandom_range(12);
    s.m1y = $signed($urandom()) >>> $urandom_range(12);
    s.tx  = s.p0x + $signed(32'($urandom_range(span + span / 8))) - span / 16;
    return s;
  endfunction

  // Offer one segment, holding it steady until the block accepts it. Valid is only
  // dropped while the sender idles, so back-to-back transactions keep it high.
  task automatic send_segment(seg_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    seg <= s;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_segment(rand_segment());
  endtask

  initial begin
    seg_t s;
    int waited;
    src_idle_pct = 19;
    dst_idle_pct = 66;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zeros, extremes, ties at the ends, wild tangents and every bit toggled.
    send_segment('0);
    send_segment('{9{32'sh7fffffff}});
    send_segment('{9{32'sh80000000}});
    send_segment('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sd0});
    send_segment('{0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 0});
    send_segment('{0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000});
    send_segment('{0, 32'sh7fffffff, 32'sh10000, 32'sh80000000, 32'sh10000, 32'sh7fffffff,
                   32'sh10000, 32'sh7fffffff, 32'sh8000});
    send_segment('{0, 0, 32'sh10000, 32'sh10000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh8000});
    send_segment('{32'sh10000, 5, 0, 7, 32'shffff0000, 3, 32'shffff0000, 1, 32'sh8000});
    send_segment('{9{32'sh55555555}});
    send_segment('{9{32'shaaaaaaaa}});
    send_segment('{9{32'sh00000001}});
    send_segment('{9{32'shffffffff}});
    for (int i = 0; i < 8; i++) begin
      s = rand_segment();
      s.tx = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      send_segment(s);
    end

    // Long hold-off on the receiver while segments keep coming, so the pipeline fills.
    dst_hold = 1'b1;
    fork
      begin
        for (int c = 0; c < 3 * LATENCY; c++) @(posedge clk_i);
        dst_hold = 1'b0;
      end
      run_random(2 * LATENCY);
    join

    run_random(400);
    src_idle_pct = 66;
    dst_idle_pct = 19;
    run_random(400);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random(300);
    src_idle_pct = 10;
    dst_idle_pct = 10;
    run_random(160);
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d segments and checked %0d curve y results, with bursts, gaps and a",
             sent, results);
    $display("long receiver stall; directed cases covered extremes, ties and wild tangents.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
